// ===== rtl/lpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int unsigned HdrLen     = 16;
  localparam int unsigned HdrCntW    = 4;
  localparam int unsigned CfgIndexW  = 8;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [15:0] MagicReset   = 16'd11111;
  localparam logic [7:0]  VersionReset = 8'd10;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexW-1:0] CFG_EXPECTED_MAGIC  = 8'd0;
  localparam logic [CfgIndexW-1:0] CFG_HIGHEST_VERSION = 8'd1;

  // Result status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC   = 2'd1;
  localparam logic [1:0] ST_BAD_VERSION = 2'd2;
  localparam logic [1:0] ST_SHORT_SIZE  = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  payload_byte;
    logic        has_payload;
    logic [7:0]  command;
    logic [63:0] seq_id;
    logic        first_of_message;
    logic        last_of_message;
  } lpfd_result_t;

  // Handshake between the parser core and the output register.
  typedef struct packed {
    logic fire;
    logic res_valid;
  } lpfd_ctrl_t;

endpackage

// ===== rtl/lpfd_in_reg.sv =====
// ----------------------------------------------------------------------------
// lpfd_in_reg
// Input register: holds one stream word until the parser consumes it.
// ----------------------------------------------------------------------------
module lpfd_in_reg import lpfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       consume,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  // A new word may enter when the register is empty or is emptied this cycle.
  assign in_stall  = valid_r && !consume;
  assign accept    = in_valid && !in_stall;
  assign valid_nxt = accept ? 1'b1 : (consume ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_data_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

// ===== rtl/lpfd_core.sv =====
// ----------------------------------------------------------------------------
// lpfd_core
// Header collection and check, body byte counting and configuration registers.
// ----------------------------------------------------------------------------
module lpfd_core import lpfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  input  logic                 fire,
  input  logic [7:0]           data_byte,
  output logic                 res_valid,
  output lpfd_result_t         result
);

  logic [15:0]        magic_r;
  logic [7:0]         version_r;
  logic [HdrCntW-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]        meta_r, meta_nxt;
  logic [63:0]        seq_r, seq_nxt;
  logic [31:0]        len_r, len_nxt;
  logic [31:0]        left_r, left_nxt;
  logic               in_body_r, in_body_nxt;
  logic               first_r, first_nxt;
  logic [1:0]         status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= MagicReset;
      version_r <= VersionReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_EXPECTED_MAGIC:  magic_r   <= cfg_wdata;
        CFG_HIGHEST_VERSION: version_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    meta_nxt    = meta_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    in_body_nxt = in_body_r;
    first_nxt   = first_r;
    status      = ST_OK;
    res_valid   = 1'b0;
    result      = '0;

    if (in_body_r) begin
      left_nxt    = left_r - 32'd1;
      first_nxt   = 1'b0;
      in_body_nxt = (left_nxt != 32'd0);
      res_valid   = 1'b1;
      result.status           = ST_OK;
      result.payload_byte     = data_byte;
      result.has_payload      = 1'b1;
      result.command          = meta_r[7:0];
      result.seq_id           = seq_r;
      result.first_of_message = first_r;
      result.last_of_message  = !in_body_nxt;
    end else begin
      if (hdr_cnt_r < HdrCntW'(4)) begin
        meta_nxt = {meta_r[23:0], data_byte};
      end else if (hdr_cnt_r < HdrCntW'(12)) begin
        seq_nxt = {seq_r[55:0], data_byte};
      end else begin
        len_nxt = {len_r[23:0], data_byte};
      end
      // The counter wraps to zero after the last header byte.
      hdr_cnt_nxt = hdr_cnt_r + HdrCntW'(1);

      if (hdr_cnt_r == HdrCntW'(HdrLen - 1)) begin
        if (meta_nxt[31:16] != magic_r) begin
          status = ST_BAD_MAGIC;
        end else if (meta_nxt[15:8] > version_r) begin
          status = ST_BAD_VERSION;
        end else if (len_nxt < 32'(HdrLen)) begin
          status = ST_SHORT_SIZE;
        end

        res_valid = 1'b1;
        if (status != ST_OK) begin
          result.status = status;
        end else begin
          left_nxt = len_nxt - 32'(HdrLen);
          if (left_nxt == 32'd0) begin
            // Empty body: a single marker word carries the header fields.
            result.command          = meta_nxt[7:0];
            result.seq_id           = seq_nxt;
            result.first_of_message = 1'b1;
            result.last_of_message  = 1'b1;
          end else begin
            res_valid   = 1'b0;
            in_body_nxt = 1'b1;
            first_nxt   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r <= '0;
      meta_r    <= '0;
      seq_r     <= '0;
      len_r     <= '0;
      left_r    <= '0;
      in_body_r <= 1'b0;
      first_r   <= 1'b0;
    end else if (fire) begin
      hdr_cnt_r <= hdr_cnt_nxt;
      meta_r    <= meta_nxt;
      seq_r     <= seq_nxt;
      len_r     <= len_nxt;
      left_r    <= left_nxt;
      in_body_r <= in_body_nxt;
      first_r   <= first_nxt;
    end
  end

  a_body_no_header: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (hdr_cnt_r == '0))
    else $error("header counter busy while forwarding body");

  a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (left_r != 32'd0))
    else $error("in body with no bytes left");

  a_first_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    first_r |-> in_body_r)
    else $error("first flag pending outside a body");

  a_body_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_body_r && left_r == 32'd1) |=> !in_body_r)
    else $error("body did not end after its last byte");

endmodule

// ===== rtl/lpfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// lpfd_out_reg
// Output register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module lpfd_out_reg import lpfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  lpfd_ctrl_t   ctrl,
  input  lpfd_result_t result,
  output logic         free,
  output logic         out_valid,
  input  logic         out_stall,
  output lpfd_result_t out_result
);

  logic         valid_r, valid_nxt;
  lpfd_result_t res_r;
  logic         load;

  assign free      = !valid_r || !out_stall;
  assign load      = ctrl.fire && ctrl.res_valid;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = res_r;

endmodule

// ===== rtl/length_prefixed_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Splits a byte stream into frames with a 16-byte big-endian header.
// ----------------------------------------------------------------------------
// The input channel carries one stream byte per word; the output channel
// carries one result word per body byte, one marker word for an empty body,
// or one error word for a header that fails its check. Header bytes give no
// output word. Words move when valid is high and stall is low.
// Throughput is one byte per cycle while the receiver does not stall. A byte
// accepted into the input register is parsed when the result register is
// free, and its result word is loaded into the result register at that same
// edge; the byte passes through the input register and the result register.
// When the receiver stalls with a word waiting, the result register holds
// that word and the parser stops; the input register holds at most one more
// byte, and the input channel stalls as soon as it is full. The configuration
// registers take a write on any cycle with cfg_wr_en high and are used at
// the next header check.
// Reset returns the block to hunting for a header with the configuration
// registers at their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer import lpfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [7:0]           out_payload_byte,
  output logic                 out_has_payload,
  output logic [7:0]           out_command,
  output logic [63:0]          out_seq_id,
  output logic                 out_first_of_message,
  output logic                 out_last_of_message
);

  logic         held_valid;
  logic [7:0]   held_byte;
  logic         free;
  logic         fire;
  logic         res_valid;
  lpfd_ctrl_t   ctrl;
  lpfd_result_t result;
  lpfd_result_t out_result;

  // The parser advances only when the result register can take a word.
  assign fire = held_valid && free;
  assign ctrl = {fire, res_valid};

  lpfd_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .consume      (fire),
    .held_valid   (held_valid),
    .held_byte    (held_byte)
  );

  lpfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .data_byte (held_byte),
    .res_valid (res_valid),
    .result    (result)
  );

  lpfd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .result     (result),
    .free       (free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_status           = out_result.status;
  assign out_payload_byte     = out_result.payload_byte;
  assign out_has_payload      = out_result.has_payload;
  assign out_command          = out_result.command;
  assign out_seq_id           = out_result.seq_id;
  assign out_first_of_message = out_result.first_of_message;
  assign out_last_of_message  = out_result.last_of_message;

endmodule

// ===== tb/sv/lpfd_frame_checker.sv =====
// ----------------------------------------------------------------------------
// lpfd_frame_checker
// Watches both channels of the frame deframer and checks every result word.
// ----------------------------------------------------------------------------
// Each byte that the block accepts goes through a local frame parser. The
// parser keeps its own header counter, header fields, body counter and copy
// of the configuration registers. A body byte, or a byte that completes a
// header with a fault or an empty body, queues the result word the block
// should give. Each result word that the block hands over is compared field
// by field with the oldest queued word. The module reports the number of
// mismatches and the number of words still owed to the stimulus side.
// ----------------------------------------------------------------------------
module lpfd_frame_checker import lpfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_status,
  input  logic [7:0]           out_payload_byte,
  input  logic                 out_has_payload,
  input  logic [7:0]           out_command,
  input  logic [63:0]          out_seq_id,
  input  logic                 out_first_of_message,
  input  logic                 out_last_of_message,
  output int                   mismatches,
  output int                   awaiting
);

  // Local copy of the configuration registers.
  logic [15:0] magic_reg;
  logic [7:0]  max_version_reg;

  // Frame parser state.
  logic [4:0]  hdr_count;
  logic [31:0] meta_word;
  logic [63:0] seq_word;
  logic [31:0] size_word;
  logic [31:0] body_left;
  logic        in_body;
  logic        first_pending;

  lpfd_result_t pending_results[$];
  int           words_seen;

  initial begin
    mismatches = 0;
    awaiting   = 0;
    words_seen = 0;
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 100)
      $display("word %0d: %s is %0h, should be %0h", words_seen, field, got, want);
    mismatches++;
  endtask

  task automatic reset_parser();
    magic_reg       = MagicReset;
    max_version_reg = VersionReset;
    hdr_count       = '0;
    meta_word       = '0;
    seq_word        = '0;
    size_word       = '0;
    body_left       = '0;
    in_body         = 1'b0;
    first_pending   = 1'b0;
  endtask

  // Runs one stream byte through the parser; res is valid when produced is set.
  task automatic parse_byte(input logic [7:0] b, output bit produced,
                            output lpfd_result_t res);
    logic [1:0] st;
    res      = '0;
    produced = 1'b0;
    if (in_body) begin
      body_left     = body_left - 32'd1;
      res.status           = ST_OK;
      res.payload_byte     = b;
      res.has_payload      = 1'b1;
      res.command          = meta_word[7:0];
      res.seq_id           = seq_word;
      res.first_of_message = first_pending;
      first_pending = 1'b0;
      if (body_left == 32'd0)
        in_body = 1'b0;
      res.last_of_message  = !in_body;
      produced = 1'b1;
    end else begin
      if (hdr_count < 5'd4)
        meta_word = {meta_word[23:0], b};
      else if (hdr_count < 5'd12)
        seq_word = {seq_word[55:0], b};
      else
        size_word = {size_word[23:0], b};
      hdr_count = hdr_count + 5'd1;
      if (hdr_count == 5'(HdrLen)) begin
        hdr_count = '0;
        // Faults are ranked: magic first, then version, then size.
        if (meta_word[31:16] != magic_reg)
          st = ST_BAD_MAGIC;
        else if (meta_word[15:8] > max_version_reg)
          st = ST_BAD_VERSION;
        else if (size_word < 32'(HdrLen))
          st = ST_SHORT_SIZE;
        else
          st = ST_OK;
        if (st != ST_OK) begin
          res.status = st;
          produced   = 1'b1;
        end else begin
          body_left = size_word - 32'(HdrLen);
          if (body_left == 32'd0) begin
            res.status           = ST_OK;
            res.command          = meta_word[7:0];
            res.seq_id           = seq_word;
            res.first_of_message = 1'b1;
            res.last_of_message  = 1'b1;
            produced = 1'b1;
          end else begin
            in_body       = 1'b1;
            first_pending = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic check_word(input lpfd_result_t want);
    if (out_status !== want.status)
      report_mismatch("status", 64'(out_status), 64'(want.status));
    if (out_payload_byte !== want.payload_byte)
      report_mismatch("payload_byte", 64'(out_payload_byte),
                      64'(want.payload_byte));
    if (out_has_payload !== want.has_payload)
      report_mismatch("has_payload", 64'(out_has_payload),
                      64'(want.has_payload));
    if (out_command !== want.command)
      report_mismatch("command", 64'(out_command), 64'(want.command));
    if (out_seq_id !== want.seq_id)
      report_mismatch("seq_id", out_seq_id, want.seq_id);
    if (out_first_of_message !== want.first_of_message)
      report_mismatch("first_of_message", 64'(out_first_of_message),
                      64'(want.first_of_message));
    if (out_last_of_message !== want.last_of_message)
      report_mismatch("last_of_message", 64'(out_last_of_message),
                      64'(want.last_of_message));
  endtask

  always @(posedge clk) begin
    lpfd_result_t next_word;
    bit           made_word;
    if (!rst_n) begin
      reset_parser();
      pending_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_EXPECTED_MAGIC:  magic_reg = cfg_wdata;
          CFG_HIGHEST_VERSION: max_version_reg = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // A word leaving the block can never stem from a byte taken at the same
      // edge, so it is matched before that byte is parsed.
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0)
          report_mismatch("unexpected word, status", 64'(out_status), '0);
        else
          check_word(pending_results.pop_front());
        words_seen++;
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        parse_byte(in_data_byte, made_word, next_word);
        if (made_word)
          pending_results.push_back(next_word);
      end
    end
    awaiting = pending_results.size();
  end

endmodule

// ===== tb/sv/tb_length_prefixed_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_length_prefixed_frame_deframer
// Stimulus and verdict for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
// A short directed part sends headers at the field extremes, the size fault
// alone and faults combined, empty and one-byte bodies, a long receiver
// hold-off and a register change in the middle of a header. Random frames
// follow under several register settings, mostly well formed with random
// content and the rest with a bad magic, version or size. Both sides idle in
// short random bursts except in the last phase. The checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_length_prefixed_frame_deframer;
  import lpfd_pkg::*;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_wr_en    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index    = '0;
  logic [CfgDataW-1:0]  cfg_wdata    = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_data_byte = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [1:0]           out_status;
  logic [7:0]           out_payload_byte;
  logic                 out_has_payload;
  logic [7:0]           out_command;
  logic [63:0]          out_seq_id;
  logic                 out_first_of_message;
  logic                 out_last_of_message;

  int mismatches;
  int awaiting;

  // Stimulus controls shared with the receiver process.
  bit sender_idle   = 1'b1;
  bit receiver_idle = 1'b1;
  bit hold_request  = 1'b0;
  int bytes_sent    = 0;
  int cur_magic     = MagicReset;
  int cur_max_ver   = VersionReset;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  length_prefixed_frame_deframer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_payload_byte     (out_payload_byte),
    .out_has_payload      (out_has_payload),
    .out_command          (out_command),
    .out_seq_id           (out_seq_id),
    .out_first_of_message (out_first_of_message),
    .out_last_of_message  (out_last_of_message)
  );

  lpfd_frame_checker chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_payload_byte     (out_payload_byte),
    .out_has_payload      (out_has_payload),
    .out_command          (out_command),
    .out_seq_id           (out_seq_id),
    .out_first_of_message (out_first_of_message),
    .out_last_of_message  (out_last_of_message),
    .mismatches           (mismatches),
    .awaiting             (awaiting)
  );

  initial begin
    #400000;
    $display("** length_prefixed_frame_deframer: FAILED **");
    $finish;
  end

  // Receiver: short random stalls, or one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (48) @(posedge clk);
        out_stall <= 1'b0;
      end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic [127:0] make_header(input logic [15:0] magic,
      input logic [7:0] version, input logic [7:0] command,
      input logic [63:0] seq_id, input logic [31:0] size);
    return {magic, version, command, seq_id, size};
  endfunction

  task automatic send_header_span(input logic [127:0] hdr, input int first_b,
                                  input int last_b);
    for (int i = first_b; i <= last_b; i++)
      push_byte(hdr[127 - 8*i -: 8]);
  endtask

  task automatic send_body(input int count);
    for (int i = 0; i < count; i++)
      push_byte(8'($urandom));
  endtask

  task automatic send_frame(input logic [15:0] magic, input logic [7:0] version,
      input logic [7:0] command, input logic [63:0] seq_id,
      input logic [31:0] size, input int body_count);
    send_header_span(make_header(magic, version, command, seq_id, size), 0, 15);
    send_body(body_count);
  endtask

  // Stops offering words until every owed result has come out, then lets
  // the pipeline settle, since header bytes leave no word behind.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic set_config(input int magic, input int max_ver);
    wait_idle();
    write_reg(CFG_EXPECTED_MAGIC, 16'(magic));
    // Upper data bits are junk; the version register keeps only its low byte.
    write_reg(CFG_HIGHEST_VERSION, {8'($urandom), 8'(max_ver)});
    cfg_wr_en <= 1'b0;
    cur_magic   = magic;
    cur_max_ver = max_ver;
  endtask

  task automatic random_frame();
    int          pick;
    int          body_n;
    logic [63:0] seq_id;
    pick   = $urandom_range(0, 99);
    seq_id = {$urandom, $urandom};
    if (pick < 70) begin
      body_n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      send_frame(16'(cur_magic), 8'($urandom_range(0, cur_max_ver)), 8'($urandom),
                 seq_id, 32'(16 + body_n), body_n);
    end else if (pick < 80) begin
      send_frame(16'(cur_magic) ^ 16'($urandom_range(1, 65535)), 8'($urandom),
                 8'($urandom), seq_id, $urandom, 0);
    end else if (pick < 90 && cur_max_ver < 255) begin
      send_frame(16'(cur_magic), 8'($urandom_range(cur_max_ver + 1, 255)), 8'($urandom),
                 seq_id, $urandom, 0);
    end else begin
      send_frame(16'(cur_magic), 8'($urandom_range(0, cur_max_ver)), 8'($urandom),
                 seq_id, 32'($urandom_range(0, 15)), 0);
    end
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) random_frame();
  endtask

  initial begin
    logic [127:0] split_hdr;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty body at the highest allowed version, all-ones command and id.
    send_frame(MagicReset, VersionReset, 8'hFF, '1, 32'd16, 0);
    // Three body bytes including both byte extremes; version, command, id all zero.
    send_frame(MagicReset, 8'd0, 8'h00, '0, 32'd19, 0);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h5A);
    // A one-byte body is both first and last.
    send_frame(MagicReset, 8'd3, 8'h42, 64'h0123_4567_89AB_CDEF, 32'd17, 1);
    // Every fault at once: the magic check wins.
    send_frame(16'hFFFF, 8'hFF, 8'hFF, '1, 32'd0, 0);
    // Version too high and size too small: the version check wins.
    send_frame(MagicReset, VersionReset + 8'd1, 8'h07, 64'h1, 32'd0, 0);
    // Size just below the header length.
    send_frame(MagicReset, VersionReset, 8'h07, 64'h2, 32'd15, 0);

    // Long receiver hold-off while the sender keeps offering body bytes.
    sender_idle  = 1'b0;
    hold_request = 1'b1;
    send_frame(MagicReset, 8'd1, 8'h09, {$urandom, $urandom}, 32'd56, 40);
    sender_idle  = 1'b1;
    wait_idle();

    // Register change between the two halves of one header.
    split_hdr = make_header(16'h0000, 8'd0, 8'h33, {$urandom, $urandom}, 32'd18);
    send_header_span(split_hdr, 0, 7);
    set_config(0, 0);
    send_header_span(split_hdr, 8, 15);
    send_body(2);

    random_phase(190);
    set_config(16'hFFFF, 255);
    random_phase(190);
    set_config($urandom_range(0, 65535), $urandom_range(0, 255));
    random_phase(190);
    set_config($urandom_range(0, 65535), $urandom_range(0, 255));
    random_phase(190);
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    set_config(MagicReset, VersionReset);
    random_phase(190);

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && awaiting == 0)
      $display("** length_prefixed_frame_deframer: PASSED **");
    else
      $display("** length_prefixed_frame_deframer: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lpfd_pkg.sv
rtl/lpfd_in_reg.sv
rtl/lpfd_core.sv
rtl/lpfd_out_reg.sv
rtl/length_prefixed_frame_deframer.sv
tb/sv/lpfd_frame_checker.sv
tb/sv/tb_length_prefixed_frame_deframer.sv
